/* rtl/lapet_pkg.sv */
// Package for the Laplacian edge threshold block: constants, the config struct
// and the gray conversion. Used by every module and by the pixel channel interface.
// Depends on nothing else.
package lapet_pkg;

  // Widths fixed by the channel and register definitions.
  localparam int unsigned COLOR_W  = 8;
  localparam int unsigned WIDTH_W  = 11;
  localparam int unsigned HEIGHT_W = 16;
  localparam int unsigned THR_W    = 8;

  // Command codes carried on the pixel channel.
  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  // Register indexes on the configuration port (word address).
  localparam logic [1:0] REG_IMAGE_WIDTH    = 2'd0;
  localparam logic [1:0] REG_IMAGE_HEIGHT   = 2'd1;
  localparam logic [1:0] REG_EDGE_THRESHOLD = 2'd2;

  // Register reset values.
  localparam logic [WIDTH_W-1:0]  RST_IMAGE_WIDTH    = 11'd640;
  localparam logic [HEIGHT_W-1:0] RST_IMAGE_HEIGHT   = 16'd480;
  localparam logic [THR_W-1:0]    RST_EDGE_THRESHOLD = 8'd128;

  // Gray weights in 1/256 units, with rounding offset.
  localparam logic [15:0] GRAY_R_COEF = 16'd77;
  localparam logic [15:0] GRAY_G_COEF = 16'd150;
  localparam logic [15:0] GRAY_B_COEF = 16'd29;
  localparam logic [15:0] GRAY_ROUND  = 16'd128;

  typedef struct packed {
    logic [WIDTH_W-1:0]  image_width;
    logic [HEIGHT_W-1:0] image_height;
    logic [THR_W-1:0]    edge_threshold;
  } lapet_cfg_t;

  // Weighted sum of the three components; the weights add to 256, so the
  // sum never exceeds 16 bits.
  function automatic logic [COLOR_W-1:0] gray8(input logic [COLOR_W-1:0] r,
                                               input logic [COLOR_W-1:0] g,
                                               input logic [COLOR_W-1:0] b);
    logic [15:0] sum;
    sum = GRAY_R_COEF * 16'(r) + GRAY_G_COEF * 16'(g) + GRAY_B_COEF * 16'(b)
          + GRAY_ROUND;
    return sum[15:8];
  endfunction

endpackage

/* rtl/lapet_if.sv */
// Channel interfaces of the Laplacian edge threshold block: the pixel word
// channel and the result word channel. Depends on lapet_pkg.
interface lapet_pix_if import lapet_pkg::*; ;
  logic               valid;
  logic               ready;
  logic               command;
  logic [COLOR_W-1:0] red;
  logic [COLOR_W-1:0] green;
  logic [COLOR_W-1:0] blue;

  modport source(output valid, command, red, green, blue, input ready);
  modport sink(input valid, command, red, green, blue, output ready);
endinterface

interface lapet_res_if;
  logic valid;
  logic ready;
  logic edge_res;
  logic end_of_frame;

  modport source(output valid, edge_res, end_of_frame, input ready);
  modport sink(input valid, edge_res, end_of_frame, output ready);
endinterface

/* rtl/lapet_cfg.sv */
// APB-style register file holding width, height and threshold.
// Depends on lapet_pkg for the register struct, indexes and reset values.
module lapet_cfg import lapet_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output lapet_cfg_t  cfg
);

  logic [1:0] reg_idx;
  logic       wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;

  // Register writes; addresses past the list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.image_width    <= RST_IMAGE_WIDTH;
      cfg.image_height   <= RST_IMAGE_HEIGHT;
      cfg.edge_threshold <= RST_EDGE_THRESHOLD;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_IMAGE_WIDTH:    cfg.image_width    <= pwdata[WIDTH_W-1:0];
        REG_IMAGE_HEIGHT:   cfg.image_height   <= pwdata[HEIGHT_W-1:0];
        REG_EDGE_THRESHOLD: cfg.edge_threshold <= pwdata[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // Read data, zero extended.
  always_comb begin
    unique case (reg_idx)
      REG_IMAGE_WIDTH:    prdata = 32'(cfg.image_width);
      REG_IMAGE_HEIGHT:   prdata = 32'(cfg.image_height);
      REG_EDGE_THRESHOLD: prdata = 32'(cfg.edge_threshold);
      default:            prdata = '0;
    endcase
  end

endmodule

/* rtl/lapet_line_mem.sv */
// Line store: one write port and one registered read port with enable.
// Each word packs the previous row's gray value over the one before it.
// Depends on lapet_pkg only by convention of the project.
module lapet_line_mem import lapet_pkg::*; #(
  parameter int unsigned DEPTH  = 1024,
  parameter int unsigned DATA_W = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [DATA_W-1:0]        wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [DATA_W-1:0]        rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port; data holds while the read is not enabled.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/lapet_ctrl.sv */
// Pixel pipeline: input register with gray conversion, column and row
// counters, 3x3 cross window, Laplacian threshold and result register.
// Depends on lapet_pkg and the channel interfaces; drives the line store.
module lapet_ctrl import lapet_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned PIXEL_BITS = 8,
  localparam int unsigned COL_W  = $clog2(MAX_WIDTH),
  localparam int unsigned WORD_W = 2 * PIXEL_BITS
) (
  input  logic              clk,
  input  logic              rst,
  input  lapet_cfg_t        cfg,
  lapet_pix_if.sink         pixels,
  lapet_res_if.source       results,
  output logic              mem_wr_en,
  output logic [COL_W-1:0]  mem_wr_addr,
  output logic [WORD_W-1:0] mem_wr_data,
  output logic              mem_rd_en,
  output logic [COL_W-1:0]  mem_rd_addr,
  input  logic [WORD_W-1:0] mem_rd_data
);

  localparam int unsigned PB     = PIXEL_BITS;
  localparam int unsigned WCMP_W = (COL_W + 1 > WIDTH_W) ? COL_W + 1 : WIDTH_W;
  localparam int unsigned GCMP_W = (PB > COLOR_W) ? PB : COLOR_W;
  localparam int unsigned TCMP_W = (PB > THR_W) ? PB : THR_W;
  localparam int unsigned SUM_W  = PB + 2;
  localparam logic [PB-1:0] PIX_MAX = '1;

  // Input register.
  logic          in_valid;
  logic          in_cmd;
  logic [PB-1:0] in_gray;
  logic [COLOR_W-1:0] gray_raw;
  logic [PB-1:0]      gray_sat;

  // Frame position.
  logic [COL_W-1:0]    col;
  logic [HEIGHT_W-1:0] row;
  logic                drain;
  logic [COL_W-1:0]    dcol;

  // Window: pixel left of centre, word at centre, word right of centre.
  logic [PB-1:0]     lpix;
  logic [WORD_W-1:0] cur_word;
  logic [WORD_W-1:0] nxt_hold;
  logic              nxt_from_mem;
  logic [WORD_W-1:0] first_word0;
  logic [WORD_W-1:0] first_word1;
  logic [WORD_W-1:0] nxt_word;

  // Result register.
  logic res_valid;
  logic res_edge;
  logic res_eof;

  // Step control.
  logic                proc;
  logic                is_flush;
  logic                active;
  logic                produce;
  logic [COL_W-1:0]    x;
  logic [WCMP_W-1:0]   w_eff;
  logic [HEIGHT_W-1:0] h_eff;
  logic [WCMP_W-1:0]   x_plus1;
  logic                last_col;
  logic                last_row;
  logic [COL_W:0]      x_plus2;
  logic [WORD_W-1:0]   wr_word;

  // Kernel.
  logic [PB-1:0]     pc, pu, pd, pl, pr;
  logic [SUM_W-1:0]  pos_sum, neg_sum, diff;
  logic [PB-1:0]     lap;
  logic              edge_next;

  // Gray conversion ahead of the input register, saturated to the pixel range.
  always_comb begin
    gray_raw = gray8(pixels.red, pixels.green, pixels.blue);
    if (GCMP_W'(gray_raw) > GCMP_W'(PIX_MAX)) begin
      gray_sat = PIX_MAX;
    end else begin
      gray_sat = PB'(gray_raw);
    end
  end

  // Handshake: a word moves on whenever the result register is free or drains.
  assign proc          = in_valid && (!res_valid || results.ready);
  assign pixels.ready  = !in_valid || proc;
  assign results.valid = res_valid;
  assign results.edge_res     = res_edge;
  assign results.end_of_frame = res_eof;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (pixels.valid && pixels.ready) begin
      in_valid <= 1'b1;
    end else if (proc) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pixels.valid && pixels.ready) begin
      in_cmd  <= pixels.command;
      in_gray <= gray_sat;
    end
  end

  // Effective frame size and the column of this word.
  always_comb begin
    if (cfg.image_width == '0) begin
      w_eff = WCMP_W'(1);
    end else if (WCMP_W'(cfg.image_width) > WCMP_W'(MAX_WIDTH)) begin
      w_eff = WCMP_W'(MAX_WIDTH);
    end else begin
      w_eff = WCMP_W'(cfg.image_width);
    end
    h_eff = (cfg.image_height == '0) ? HEIGHT_W'(1) : cfg.image_height;

    is_flush = (in_cmd == CMD_FLUSH);
    active   = proc && (is_flush ? drain : !drain);
    x        = is_flush ? dcol : col;
    x_plus1  = WCMP_W'(x) + WCMP_W'(1);
    last_col = (x_plus1 >= w_eff);
    last_row = ({1'b0, row} + (HEIGHT_W + 1)'(1)) >= {1'b0, h_eff};
    produce  = active && (is_flush || (row != '0));
    x_plus2  = {1'b0, x} + (COL_W + 1)'(2);
  end

  // Window taps with border replication.
  assign nxt_word = nxt_from_mem ? mem_rd_data : nxt_hold;

  always_comb begin
    pc = cur_word[WORD_W-1:PB];
    pl = (x != '0) ? lpix : pc;
    pr = (x_plus1 < w_eff) ? nxt_word[WORD_W-1:PB] : pc;
    if (is_flush) begin
      pu = (row >= HEIGHT_W'(1)) ? cur_word[PB-1:0] : pc;
      pd = pc;
    end else begin
      pu = (row >= HEIGHT_W'(2)) ? cur_word[PB-1:0] : pc;
      pd = in_gray;
    end
    wr_word = {in_gray, pc};
  end

  // Four times the centre less the cross neighbours, clamped and compared.
  always_comb begin
    pos_sum = {pc, 2'b00};
    neg_sum = SUM_W'(pu) + SUM_W'(pd) + SUM_W'(pl) + SUM_W'(pr);
    diff    = pos_sum - neg_sum;
    if (neg_sum >= pos_sum) begin
      lap = '0;
    end else if (diff[SUM_W-1:PB] != '0) begin
      lap = PIX_MAX;
    end else begin
      lap = diff[PB-1:0];
    end
    edge_next = TCMP_W'(lap) > TCMP_W'(cfg.edge_threshold);
  end

  // Line store traffic: write the finished column, prefetch two ahead.
  always_comb begin
    mem_wr_en   = active && !is_flush;
    mem_wr_addr = x;
    mem_wr_data = wr_word;
    mem_rd_en   = active;
    if (x_plus2 >= (COL_W + 1)'(MAX_WIDTH)) begin
      mem_rd_addr = '0;
    end else begin
      mem_rd_addr = x_plus2[COL_W-1:0];
    end
  end

  // Counters and drain state.
  always_ff @(posedge clk) begin
    if (rst) begin
      col   <= '0;
      row   <= '0;
      drain <= 1'b0;
      dcol  <= '0;
    end else if (active) begin
      if (is_flush) begin
        if (last_col) begin
          drain <= 1'b0;
          dcol  <= '0;
          row   <= '0;
          col   <= '0;
        end else begin
          dcol <= x_plus1[COL_W-1:0];
        end
      end else if (last_col) begin
        col <= '0;
        if (last_row) begin
          drain <= 1'b1;
          dcol  <= '0;
        end else begin
          row <= row + HEIGHT_W'(1);
        end
      end else begin
        col <= x_plus1[COL_W-1:0];
      end
    end
  end

  // Window shift; at a row end the first two words of the row just written
  // become the window for column zero of the next row.
  always_ff @(posedge clk) begin
    if (rst) begin
      nxt_from_mem <= 1'b0;
    end else if (active) begin
      if (!is_flush && last_col) begin
        nxt_from_mem <= 1'b0;
      end else begin
        nxt_from_mem <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (active) begin
      if (!is_flush && last_col) begin
        cur_word <= (x == '0) ? wr_word : first_word0;
        nxt_hold <= (x == COL_W'(1)) ? wr_word : first_word1;
      end else begin
        lpix     <= pc;
        cur_word <= nxt_word;
      end
      if (!is_flush && x == '0) begin
        first_word0 <= wr_word;
      end
      if (!is_flush && x == COL_W'(1)) begin
        first_word1 <= wr_word;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (proc) begin
      res_valid <= produce;
    end else if (results.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (produce) begin
      res_edge <= edge_next;
      res_eof  <= is_flush && last_col;
    end
  end

  // The pixel column counter stays at zero throughout the drain.
  a_drain_col: assert property (@(posedge clk) disable iff (rst)
    drain |-> (col == '0))
    else $error("column counter not at zero during drain");

  // The drain opens only on the last pixel of a frame.
  a_drain_start: assert property (@(posedge clk) disable iff (rst)
    $rose(drain) |-> $past(active && !is_flush && last_col && last_row))
    else $error("drain started away from frame end");

  // A waiting end-of-frame result means the drain is over.
  a_eof_drained: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_eof) |-> !drain)
    else $error("end of frame result while drain still pending");

  // After a row end the window right tap comes from the held first words.
  a_row_window: assert property (@(posedge clk) disable iff (rst)
    (active && !is_flush && last_col) |=> !nxt_from_mem)
    else $error("window not reloaded at row end");

endmodule

/* rtl/laplacian_edge_threshold.sv */
// Top level of the Laplacian edge threshold block: register file, pixel
// pipeline and packed line store. Depends on lapet_pkg, lapet_if and all modules.
//
//  channel   | dir | handshake     | word
//  ----------+-----+---------------+--------------------------------------
//  pixels    | in  | valid/ready   | command, red, green, blue
//  results   | out | valid/ready   | edge_res, end_of_frame
//  apb       | in  | psel/penable  | paddr, pwdata, prdata (pready high)
//
// One word per cycle sustained while results are taken: gray conversion sits
// before the input register, and the window taps, Laplacian and threshold sit
// between the input register and the result register.
// The single line store takes one write and one prefetch read per cycle.
// Reset clears counters, drain state and valid flags; the store needs no clear.
// A stalled result holds its word and stops the pipeline behind it.
module laplacian_edge_threshold import lapet_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned PIXEL_BITS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  lapet_pix_if.sink   pixels,
  lapet_res_if.source results
);

  localparam int unsigned COL_W  = $clog2(MAX_WIDTH);
  localparam int unsigned WORD_W = 2 * PIXEL_BITS;

  lapet_cfg_t        cfg;
  logic              mem_wr_en;
  logic [COL_W-1:0]  mem_wr_addr;
  logic [WORD_W-1:0] mem_wr_data;
  logic              mem_rd_en;
  logic [COL_W-1:0]  mem_rd_addr;
  logic [WORD_W-1:0] mem_rd_data;

  // Configuration registers.
  lapet_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Two previous rows packed per column.
  lapet_line_mem #(
    .DEPTH  (MAX_WIDTH),
    .DATA_W (WORD_W)
  ) u_line_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  // Pixel pipeline.
  lapet_ctrl #(
    .MAX_WIDTH  (MAX_WIDTH),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .pixels      (pixels),
    .results     (results),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data),
    .mem_rd_en   (mem_rd_en),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data)
  );

endmodule

/* test/tb_top.sv */
// Testbench for laplacian_edge_threshold: drives pixel and flush words, programs the
// registers over APB and checks every result word against an in-bench predictor.
// Depends on lapet_pkg, the channel interfaces in lapet_if and the block's RTL.
module tb_top import lapet_pkg::*; ;

  localparam int unsigned MAXW        = 1024;
  localparam int unsigned CYCLE_LIMIT = 500000;

  typedef struct packed {
    logic edge_bit;
    logic eof;
  } mark_t;

  // Tracks the block's line stores, counters and registers, and keeps the
  // edge marks still owed by the block in arrival order.
  class edge_ledger;
    logic [WIDTH_W-1:0]  width_reg;
    logic [HEIGHT_W-1:0] height_reg;
    logic [THR_W-1:0]    thr_reg;
    bit [7:0]            rows [2*MAXW];
    int unsigned         col, row, dcol, sel;
    bit                  draining;
    mark_t               marks_due[$];
    int unsigned         errors, shown;

    function new();
      width_reg  = RST_IMAGE_WIDTH;
      height_reg = RST_IMAGE_HEIGHT;
      thr_reg    = RST_EDGE_THRESHOLD;
      col        = 0;
      row        = 0;
      dcol       = 0;
      sel        = 0;
      draining   = 1'b0;
      errors     = 0;
      shown      = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] val);
      case (idx)
        REG_IMAGE_WIDTH:    width_reg  = val[WIDTH_W-1:0];
        REG_IMAGE_HEIGHT:   height_reg = val[HEIGHT_W-1:0];
        REG_EDGE_THRESHOLD: thr_reg    = val[THR_W-1:0];
        default: ;
      endcase
    endfunction

    // A width of zero acts as one; anything above the store depth is clipped.
    function int unsigned row_len();
      if (width_reg == 0) return 1;
      if (width_reg > MAXW) return MAXW;
      return width_reg;
    endfunction

    function int unsigned frame_rows();
      return (height_reg == 0) ? 1 : height_reg;
    endfunction

    function int unsigned tap(int unsigned which, int unsigned x);
      return rows[which*MAXW + x];
    endfunction

    // Clamped cross Laplacian compared against the threshold.
    function bit over_thr(int c, int u, int d, int l, int rt);
      int v;
      v = 4*c - u - d - l - rt;
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      return v > int'(thr_reg);
    endfunction

    // Advances the tracked state by one accepted word and queues its mark.
    function void take_word(logic cmd, logic [23:0] rgb);
      int unsigned w, h, x, c, l, rt, u, gray;
      bit has_mark;
      mark_t m;
      w = row_len();
      h = frame_rows();
      has_mark = 1'b0;
      if (cmd == CMD_FLUSH) begin
        // A flush only does work while the last row is draining.
        if (!draining) return;
        x  = (dcol >= MAXW) ? MAXW - 1 : dcol;
        c  = tap(sel, x);
        l  = (x > 0) ? tap(sel, x - 1) : c;
        rt = (x + 1 < w) ? tap(sel, x + 1) : c;
        u  = (row >= 1) ? tap(sel ^ 1, x) : c;
        m.edge_bit = over_thr(c, u, c, l, rt);
        m.eof      = (x + 1 >= w);
        has_mark   = 1'b1;
        if (m.eof) begin
          draining = 1'b0;
          dcol     = 0;
          row      = 0;
          col      = 0;
        end else begin
          dcol = x + 1;
        end
      end else begin
        // Pixels that arrive during the drain are dropped.
        if (draining) return;
        x    = (col >= MAXW) ? MAXW - 1 : col;
        gray = (77*rgb[23:16] + 150*rgb[15:8] + 29*rgb[7:0] + 128) >> 8;
        if (row > 0) begin
          c  = tap(sel, x);
          l  = (x > 0) ? tap(sel, x - 1) : c;
          rt = (x + 1 < w) ? tap(sel, x + 1) : c;
          u  = (row >= 2) ? tap(sel ^ 1, x) : c;
          m.edge_bit = over_thr(c, u, gray, l, rt);
          m.eof      = 1'b0;
          has_mark   = 1'b1;
        end
        rows[(sel ^ 1)*MAXW + x] = gray[7:0];
        if (x + 1 >= w) begin
          col = 0;
          sel = sel ^ 1;
          if (row + 1 >= h) begin
            draining = 1'b1;
            dcol     = 0;
          end else begin
            row = (row + 1) & 16'hFFFF;
          end
        end else begin
          col = x + 1;
        end
      end
      if (has_mark) marks_due.push_back(m);
    endfunction

    function void note_fault(string msg);
      errors++;
      if (shown < 10) begin
        shown++;
        $display("%0t: %s", $time, msg);
      end
    endfunction

    // Compares one accepted result word with the oldest owed mark.
    function void match_result(logic eb, logic ef);
      mark_t want;
      if (marks_due.size() == 0) begin
        note_fault($sformatf("unexpected result word: edge_res %b end_of_frame %b", eb, ef));
        return;
      end
      want = marks_due.pop_front();
      if (eb !== want.edge_bit || ef !== want.eof) begin
        note_fault($sformatf("result mismatch: edge_res %b end_of_frame %b, expected %b %b",
                             eb, ef, want.edge_bit, want.eof));
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel, penable, pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic        pready;

  lapet_pix_if pix();
  lapet_res_if res();

  laplacian_edge_threshold dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .pixels  (pix),
    .results (res)
  );

  edge_ledger  ledger = new();
  int unsigned send_idle_pct = 0;
  int unsigned take_idle_pct = 0;
  int unsigned hold_left     = 0;
  int unsigned done_items    = 0;
  int unsigned cycle_count   = 0;
  int unsigned frame_no      = 0;
  logic [7:0]  tone          = 8'd128;

  // Colors of the small directed frame: black, white, mid gray and the primaries.
  logic [23:0] corner_colors [9] = '{24'h000000, 24'hFFFFFF, 24'hFF0000,
                                     24'h00FF00, 24'h0000FF, 24'hFFFFFF,
                                     24'h000000, 24'h808080, 24'hFFFFFF};

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mix of random colors, saturated channels and a slowly drifting gray.
  function logic [23:0] pick_color();
    case ($urandom_range(3))
      0: return 24'($urandom);
      1: return {{8{1'($urandom_range(1))}}, {8{1'($urandom_range(1))}},
                 {8{1'($urandom_range(1))}}};
      default: begin
        tone = tone + 8'($urandom_range(6)) - 8'd3;
        return {tone, tone + 8'($urandom_range(3)), tone};
      end
    endcase
  endfunction

  // One register write: setup phase, then access phase until pready.
  task automatic apb_write(logic [1:0] idx, logic [31:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    ledger.set_reg(idx, val);
  endtask

  // Stops offering words and waits until every owed result has come out,
  // then waits on for words still in the pipeline that owe nothing.
  task automatic wait_drained();
    pix.valid <= 1'b0;
    do @(posedge clk); while (ledger.marks_due.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_frame(logic [31:0] w, logic [31:0] h, logic [31:0] thr);
    wait_drained();
    apb_write(REG_IMAGE_WIDTH, w);
    apb_write(REG_IMAGE_HEIGHT, h);
    apb_write(REG_EDGE_THRESHOLD, thr);
  endtask

  // Offers one word, after a random gap, and holds it until accepted.
  task automatic send_word(logic cmd, logic [23:0] rgb);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      pix.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix.valid   <= 1'b1;
    pix.command <= cmd;
    pix.red     <= rgb[23:16];
    pix.green   <= rgb[15:8];
    pix.blue    <= rgb[7:0];
    do @(posedge clk); while (!pix.ready);
    ledger.take_word(cmd, rgb);
  endtask

  // A whole frame followed by its drain, with a few stray words that the
  // block drops and an optional pause that lets the results run dry.
  task automatic run_frame(int unsigned w, int unsigned h, int pause_at);
    int n;
    n = 0;
    for (int unsigned y = 0; y < h; y++) begin
      for (int unsigned x = 0; x < w; x++) begin
        if ($urandom_range(99) < 3) send_word(CMD_FLUSH, 24'($urandom));
        if (n == pause_at) wait_drained();
        send_word(CMD_PIXEL, pick_color());
        n++;
        done_items++;
      end
    end
    if ($urandom_range(99) < 30) send_word(CMD_PIXEL, pick_color());
    for (int unsigned x = 0; x < w; x++) begin
      if ($urandom_range(99) < 3) send_word(CMD_PIXEL, pick_color());
      send_word(CMD_FLUSH, 24'($urandom));
      done_items++;
    end
  endtask

  // Result side: checks accepted words and drives ready, with long
  // hold-offs counted down here when requested.
  initial begin
    res.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (res.valid && res.ready) ledger.match_result(res.edge_res, res.end_of_frame);
      if (hold_left > 0) begin
        res.ready <= 1'b0;
        hold_left--;
      end else begin
        res.ready <= ($urandom_range(99) >= take_idle_pct);
      end
    end
  end

  // Watchdog on the total run length.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    int unsigned wr, hr, thr;
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    paddr       <= '0;
    pwdata      <= '0;
    pix.valid   <= 1'b0;
    pix.command <= CMD_PIXEL;
    pix.red     <= '0;
    pix.green   <= '0;
    pix.blue    <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: flush with no drain pending, a 3x3 frame of extreme colors
    // with a pixel during the drain, then a single-pixel frame at width zero.
    send_word(CMD_FLUSH, 24'h000000);
    set_frame(3, 3, 0);
    foreach (corner_colors[i]) send_word(CMD_PIXEL, corner_colors[i]);
    send_word(CMD_PIXEL, 24'hFFFFFF);
    repeat (3) send_word(CMD_FLUSH, 24'hFFFFFF);
    set_frame(0, 1, 255);
    send_word(CMD_PIXEL, 24'hFFFFFF);
    send_word(CMD_FLUSH, 24'h000000);

    // Registers changed mid-frame: the tallest height, then a narrower row
    // and a zero height that ends the frame with the current row.
    send_idle_pct = 20;
    take_idle_pct = 20;
    set_frame(8, 65535, 100);
    repeat (27) send_word(CMD_PIXEL, pick_color());
    wait_drained();
    apb_write(REG_IMAGE_WIDTH, 5);
    apb_write(REG_IMAGE_HEIGHT, 0);
    apb_write(REG_EDGE_THRESHOLD, 40);
    repeat (2) send_word(CMD_PIXEL, pick_color());
    repeat (5) send_word(CMD_FLUSH, 24'($urandom));

    // The widest setting, clipped to the store depth: one full row, then a
    // narrower width cuts the drain short after a few columns.
    send_idle_pct = 0;
    take_idle_pct = 0;
    set_frame(2047, 1, $urandom_range(255));
    repeat (ledger.row_len()) send_word(CMD_PIXEL, pick_color());
    repeat (3) send_word(CMD_FLUSH, 24'($urandom));
    wait_drained();
    apb_write(REG_IMAGE_WIDTH, 5);
    repeat (2) send_word(CMD_FLUSH, 24'($urandom));

    // Random frames, cycling through the idling phases.
    done_items = 0;
    while (done_items < 770) begin
      case (frame_no % 5)
        1: begin send_idle_pct = 57; take_idle_pct = 0;  end
        2: begin send_idle_pct = 0;  take_idle_pct = 57; end
        3: begin send_idle_pct = 20; take_idle_pct = 20; end
        default: begin send_idle_pct = 0; take_idle_pct = 0; end
      endcase
      case ($urandom_range(19))
        0: wr = 0;
        1: wr = $urandom_range(64, 17);
        default: wr = $urandom_range(16, 1);
      endcase
      hr = $urandom_range(6);
      case ($urandom_range(9))
        0: thr = 0;
        1: thr = 255;
        default: thr = $urandom_range(255);
      endcase
      if (frame_no == 4) begin
        // Receiver holds off while the sender keeps offering words.
        wr = 12;
        hr = 8;
        send_idle_pct = 0;
      end
      set_frame(wr, hr, thr);
      if (frame_no == 4) hold_left = 300;
      run_frame(ledger.row_len(), ledger.frame_rows(),
                (frame_no % 7 == 3) ? int'(ledger.row_len() * ledger.frame_rows() / 2) : -1);
      frame_no++;
    end

    wait_drained();
    if (ledger.errors == 0 && ledger.marks_due.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule

/* filelist.f */
rtl/lapet_pkg.sv
rtl/lapet_if.sv
rtl/lapet_cfg.sv
rtl/lapet_line_mem.sv
rtl/lapet_ctrl.sv
rtl/laplacian_edge_threshold.sv
test/tb_top.sv
